[rtl/tccmb_pkg.sv]
// ----------------------------------------------------------------------------
// tccmb_pkg
// Shared types and constants for the texture coordinate clamp/mask and
// bilinear filter block.
// ----------------------------------------------------------------------------
package tccmb_pkg;

    localparam int IDX_W   = 13;
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;

    // configuration register indexes
    localparam logic [2:0] REG_S_BOUNDS  = 3'd0;
    localparam logic [2:0] REG_T_BOUNDS  = 3'd1;
    localparam logic [2:0] REG_S_MODE    = 3'd2;
    localparam logic [2:0] REG_T_MODE    = 3'd3;
    localparam logic [2:0] REG_PIPE_MODE = 3'd4;

    localparam logic CMD_COORD = 1'b0;
    localparam logic CMD_TEXEL = 1'b1;

    localparam logic KIND_FETCH = 1'b0;
    localparam logic KIND_COLOR = 1'b1;

    typedef struct packed {
        logic [23:0] s_bounds;
        logic [23:0] t_bounds;
        logic [9:0]  s_mode;
        logic [9:0]  t_mode;
        logic [2:0]  pipe_mode;
    } cfg_t;

    // one queued job: either a fetch burst or a filtered color
    typedef struct packed {
        logic             color;
        logic             point;
        logic             use0;
        logic             use3;
        logic [IDX_W-1:0] s1;
        logic [IDX_W-1:0] s2;
        logic [IDX_W-1:0] t1;
        logic [IDX_W-1:0] t2;
        logic [31:0]      rgba;
    } job_t;

endpackage

[rtl/tccmb_front.sv]
// ----------------------------------------------------------------------------
// tccmb_front
// Takes coordinate and texel transfers, runs clamp/mask per axis, collects
// texels and filters them, and pushes one job per producing transfer.
// ----------------------------------------------------------------------------
module tccmb_front
    import tccmb_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_fire,
    input  logic        cmd,
    input  logic [15:0] s_coord,
    input  logic [15:0] t_coord,
    input  logic [31:0] texel,
    output logic        push,
    output job_t        job
);

    localparam logic [7:0] CMASK = 8'((1 << CHANNEL_BITS) - 1);

    typedef struct packed {
        logic [IDX_W-1:0] i1;
        logic [IDX_W-1:0] i2;
        logic [4:0]       frac;
    } axis_t;

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [17:0] r, input logic over,
                                                   input logic doc,
                                                   input logic [IDX_W-1:0] diff);
        logic [IDX_W-1:0] x;
        begin
            if (r[16] && doc)
            begin
                x = '0;
            end
            else if (over && doc)
            begin
                x = diff;
            end
            else
            begin
                x = {r[16], r[16:5]};
            end
            return x;
        end
    endfunction

    function automatic logic [IDX_W-1:0] mask_idx(input logic [IDX_W-1:0] x,
                                                  input logic [9:0] mode);
        logic [3:0]       m;
        logic [3:0]       b;
        logic [IDX_W-1:0] bits;
        begin
            m = mode[7:4];
            b = (m > 4'd10) ? 4'd10 : m;
            bits = (IDX_W'(1) << b) - IDX_W'(1);
            if (m == 4'd0)
            begin
                return x;
            end
            else if (mode[8] && x[b])
            begin
                return ~x & bits;
            end
            else
            begin
                return x & bits;
            end
        end
    endfunction

    function automatic axis_t prep_axis(input logic [15:0] c, input logic [23:0] bounds,
                                        input logic [9:0] mode, input logic point,
                                        input logic copy);
        logic [3:0]        sh;
        logic signed [15:0] v;
        logic signed [17:0] v18;
        logic signed [17:0] v2;
        logic signed [17:0] r1;
        logic signed [17:0] r2;
        logic signed [17:0] hi_s;
        logic signed [17:0] lo8;
        logic              max1;
        logic              max2;
        logic              doc;
        logic              hit;
        logic [IDX_W-1:0]  diff;
        axis_t             a;
        begin
            sh = mode[3:0];
            if (sh == 4'd0)
            begin
                v = $signed(c);
            end
            else if (sh < 4'd11)
            begin
                v = $signed(c) >>> sh;
            end
            else
            begin
                v = $signed(c << (5'd16 - {1'b0, sh}));
            end
            v18  = 18'(v);
            v2   = v18 + 18'sd32;
            hi_s = $signed({6'd0, bounds[23:12]});
            lo8  = $signed({3'd0, bounds[11:0], 3'd0});
            max1 = (v18 >>> 3) >= hi_s;
            max2 = (v2 >>> 3) >= hi_s;
            r1   = v18 - lo8 + (point ? 18'sd16 : 18'sd0);
            r2   = v2 - lo8;
            doc  = (mode[9] || mode[7:4] == 4'd0) && !copy;
            diff = {3'd0, bounds[23:14]} - {3'd0, bounds[11:2]};
            hit  = (r1[16] || max1) && doc;
            a.frac = hit ? 5'd0 : r1[4:0];
            a.i1 = mask_idx(clamp_idx(r1, max1, doc, diff), mode);
            a.i2 = mask_idx(clamp_idx(r2, max2, doc, diff), mode);
            return a;
        end
    endfunction

    function automatic logic [7:0] filt(input logic [7:0] t0, input logic [7:0] t1,
                                        input logic [7:0] t2, input logic [7:0] t3,
                                        input logic [4:0] fs, input logic [4:0] ft,
                                        input logic upper, input logic avg);
        logic [9:0]         sum;
        logic [5:0]         ws;
        logic [5:0]         wt;
        logic signed [9:0]  ds;
        logic signed [9:0]  dt;
        logic signed [8:0]  base;
        logic signed [16:0] ps;
        logic signed [16:0] pt;
        logic signed [12:0] r;
        begin
            sum = {2'd0, t0} + {2'd0, t1} + {2'd0, t2} + {2'd0, t3};
            if (upper)
            begin
                ws   = 6'd32 - {1'b0, fs};
                wt   = 6'd32 - {1'b0, ft};
                ds   = $signed({2'd0, t2}) - $signed({2'd0, t3});
                dt   = $signed({2'd0, t1}) - $signed({2'd0, t3});
                base = $signed({1'b0, t3});
            end
            else
            begin
                ws   = {1'b0, fs};
                wt   = {1'b0, ft};
                ds   = $signed({2'd0, t1}) - $signed({2'd0, t0});
                dt   = $signed({2'd0, t2}) - $signed({2'd0, t0});
                base = $signed({1'b0, t0});
            end
            ps = $signed({1'b0, ws}) * ds;
            pt = $signed({1'b0, wt}) * dt;
            r  = 13'(base) + 13'(ps >>> 5) + 13'(pt >>> 5);
            if (avg)
            begin
                return sum[9:2];
            end
            else if (r < 0)
            begin
                return 8'd0;
            end
            else
            begin
                return r[7:0];
            end
        end
    endfunction

    logic [2:0]  exp_reg,   exp_next;
    logic [3:0]  which_reg, which_next;
    logic [4:0]  fs_reg,    fs_next;
    logic [4:0]  ft_reg,    ft_next;
    logic        upper_reg, upper_next;
    logic [31:0] slot_reg  [4];
    logic [31:0] slot_next [4];

    axis_t       ax_s;
    axis_t       ax_t;
    logic        bil;
    logic        mid;
    logic        up_c;
    logic [5:0]  fsum;
    logic [2:0]  total;
    logic [2:0]  got;
    logic [1:0]  sel;
    logic [31:0] word;
    logic        avg;
    logic [31:0] rgba;

    assign bil  = cfg.pipe_mode[0];
    assign mid  = cfg.pipe_mode[1];
    assign ax_s = prep_axis(s_coord, cfg.s_bounds, cfg.s_mode, !bil, cfg.pipe_mode[2]);
    assign ax_t = prep_axis(t_coord, cfg.t_bounds, cfg.t_mode, !bil, cfg.pipe_mode[2]);
    assign fsum = {1'b0, ax_s.frac} + {1'b0, ax_t.frac};
    assign up_c = fsum >= 6'd32;

    assign total = 3'(which_reg[0]) + 3'(which_reg[1]) + 3'(which_reg[2]) + 3'(which_reg[3]);
    assign got   = total - exp_reg;

    // fetch order is slot 1, slot 2, then slot 0 or 3, then slot 3
    always_comb
    begin
        if (which_reg == 4'b0001)
        begin
            sel = 2'd0;
        end
        else
        begin
            unique case (got[1:0])
                2'd0:    sel = 2'd1;
                2'd1:    sel = 2'd2;
                2'd2:    sel = which_reg[0] ? 2'd0 : 2'd3;
                default: sel = 2'd3;
            endcase
        end
    end

    assign word = texel & {4{CMASK}};

    always_comb
    begin
        exp_next   = exp_reg;
        which_next = which_reg;
        fs_next    = fs_reg;
        ft_next    = ft_reg;
        upper_next = upper_reg;
        for (int i = 0; i < 4; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        if (in_fire)
        begin
            if (cmd == CMD_COORD)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    slot_next[i] = '0;
                end
                if (!bil)
                begin
                    fs_next    = '0;
                    ft_next    = '0;
                    upper_next = 1'b0;
                    which_next = 4'b0001;
                    exp_next   = 3'd1;
                end
                else
                begin
                    fs_next    = ax_s.frac;
                    ft_next    = ax_t.frac;
                    upper_next = up_c;
                    which_next = {mid || up_c, 2'b11, mid || !up_c};
                    exp_next   = mid ? 3'd4 : 3'd3;
                end
            end
            else if (exp_reg != 3'd0)
            begin
                slot_next[sel] = word;
                exp_next       = exp_reg - 3'd1;
            end
        end
    end

    assign avg = which_reg == 4'b1111 && fs_reg == 5'h10 && ft_reg == 5'h10;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            rgba[8*c +: 8] = filt(slot_next[0][8*c +: 8], slot_next[1][8*c +: 8],
                                  slot_next[2][8*c +: 8], slot_next[3][8*c +: 8],
                                  fs_reg, ft_reg, upper_reg, avg);
        end
    end

    assign push = in_fire && (cmd == CMD_COORD || exp_reg == 3'd1);

    always_comb
    begin
        job.color = cmd == CMD_TEXEL;
        job.point = !bil;
        job.use0  = mid || !up_c;
        job.use3  = mid || up_c;
        job.s1    = ax_s.i1;
        job.s2    = ax_s.i2;
        job.t1    = ax_t.i1;
        job.t2    = ax_t.i2;
        job.rgba  = rgba;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg   <= '0;
            which_reg <= '0;
            fs_reg    <= '0;
            ft_reg    <= '0;
            upper_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else
        begin
            exp_reg   <= exp_next;
            which_reg <= which_next;
            fs_reg    <= fs_next;
            ft_reg    <= ft_next;
            upper_reg <= upper_next;
            for (int i = 0; i < 4; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

endmodule

[rtl/tccmb_fifo.sv]
// ----------------------------------------------------------------------------
// tccmb_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module tccmb_fifo
    import tccmb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wr_data,
    output logic full,
    input  logic pop,
    output logic rd_valid,
    output job_t rd_data
);

    job_t           mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;

    assign full     = count_reg == (QAW+1)'(QDEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

endmodule

[rtl/tccmb_back.sv]
// ----------------------------------------------------------------------------
// tccmb_back
// Expands queued jobs into fetch requests or a color result and holds them
// in the output register.
// ----------------------------------------------------------------------------
module tccmb_back
    import tccmb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_valid,
    input  job_t        rd_data,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_kind,
    output logic        out_last,
    output logic [63:0] out_data
);

    logic [1:0]       step_reg,  step_next;
    logic             valid_reg, valid_next;
    logic             kind_reg;
    logic             last_reg;
    logic [63:0]      data_reg;

    logic             load;
    logic [1:0]       final_step;
    logic             is_last;
    logic [IDX_W-1:0] fs_c;
    logic [IDX_W-1:0] ft_c;

    assign load = rd_valid && (!valid_reg || out_ready);

    assign final_step = (rd_data.color || rd_data.point) ? 2'd0
                        : 2'd1 + 2'(rd_data.use0) + 2'(rd_data.use3);
    assign is_last = step_reg == final_step;
    assign pop     = load && is_last;

    always_comb
    begin
        if (rd_data.color)
        begin
            fs_c = '0;
            ft_c = '0;
        end
        else if (rd_data.point)
        begin
            fs_c = rd_data.s1;
            ft_c = rd_data.t1;
        end
        else
        begin
            unique case (step_reg)
                2'd0:
                begin
                    fs_c = rd_data.s2;
                    ft_c = rd_data.t1;
                end
                2'd1:
                begin
                    fs_c = rd_data.s1;
                    ft_c = rd_data.t2;
                end
                2'd2:
                begin
                    fs_c = rd_data.use0 ? rd_data.s1 : rd_data.s2;
                    ft_c = rd_data.use0 ? rd_data.t1 : rd_data.t2;
                end
                default:
                begin
                    fs_c = rd_data.s2;
                    ft_c = rd_data.t2;
                end
            endcase
        end
    end

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            step_next  = is_last ? 2'd0 : step_reg + 2'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= rd_data.color ? KIND_COLOR : KIND_FETCH;
            last_reg <= is_last;
            data_reg <= {6'd0, rd_data.color ? rd_data.rgba : 32'd0, ft_c, fs_c};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;
    assign out_data  = data_reg;

endmodule

[rtl/texture_coord_clamp_mask_bilinear.sv]
// Inputs pass through the job queue and then the output register.
// Throughput: one input transfer per cycle while the job queue has room;
// the output port sets the pace: one result per cycle while m_axis_tready is high;
// a bilinear coordinate yields 3 or 4, a point coordinate or last texel of a set 1.
// Reset: rst_n clears configuration, texel slots, queue and output valid.
// ----------------------------------------------------------------------------
// texture_coord_clamp_mask_bilinear
// Texture coordinate clamp/mask with three-point bilinear filtering.
// ----------------------------------------------------------------------------
module texture_coord_clamp_mask_bilinear
    import tccmb_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // s_coord, t_coord, texel_red, texel_green, texel_blue, texel_alpha
    input  logic [63:0] s_axis_tdata,
    // cmd
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fetch_s, fetch_t, color_red, color_green, color_blue, color_alpha, zero pad
    output logic [63:0] m_axis_tdata,
    // kind
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    cfg_t cfg_reg;
    logic full;
    logic in_fire;
    logic push;
    job_t job;
    logic pop;
    logic rd_valid;
    job_t rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_S_BOUNDS:  cfg_reg.s_bounds  <= cfg_data;
                REG_T_BOUNDS:  cfg_reg.t_bounds  <= cfg_data;
                REG_S_MODE:    cfg_reg.s_mode    <= cfg_data[9:0];
                REG_T_MODE:    cfg_reg.t_mode    <= cfg_data[9:0];
                REG_PIPE_MODE: cfg_reg.pipe_mode <= cfg_data[2:0];
                default:       ;
            endcase
        end
    end

    assign s_axis_tready = !full;
    assign in_fire       = s_axis_tvalid && !full;

    tccmb_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_fire (in_fire),
        .cmd     (s_axis_tuser),
        .s_coord (s_axis_tdata[15:0]),
        .t_coord (s_axis_tdata[31:16]),
        .texel   (s_axis_tdata[63:32]),
        .push    (push),
        .job     (job)
    );

    tccmb_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (job),
        .full     (full),
        .pop      (pop),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    tccmb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_valid  (rd_valid),
        .rd_data   (rd_data),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast),
        .out_data  (m_axis_tdata)
    );

endmodule

[rtl/tccmb_checker.sv]
// ----------------------------------------------------------------------------
// tccmb_checker
// Port-level checks for the texture clamp/mask bilinear block.
// ----------------------------------------------------------------------------
module tccmb_checker
    import tccmb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled transfer keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    // a color result ends its input's results
    a_color_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_COLOR |-> m_axis_tlast)
        else $error("color result without last");

    a_color_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_COLOR |-> m_axis_tdata[25:0] == 26'd0)
        else $error("color result with fetch index");

    a_fetch_rgba: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_FETCH |-> m_axis_tdata[63:26] == 38'd0)
        else $error("fetch request with color bits");

endmodule

bind texture_coord_clamp_mask_bilinear tccmb_checker u_tccmb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
